### design/grayscale_morphology_3x3_defines.svh
// grayscale_morphology_3x3_defines.svh: assertion macros shared by the gm3 top level and gm3_ctrl
// depends on nothing; expects clk and rst in the scope where a macro is used
`ifndef GRAYSCALE_MORPHOLOGY_3X3_DEFINES_SVH
`define GRAYSCALE_MORPHOLOGY_3X3_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GM3_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("gm3 same-cycle check failed");

// next-cycle implication, checked outside reset
`define GM3_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("gm3 next-cycle check failed");

`endif

### design/gm3_pkg.sv
// gm3_pkg: types, constants and helper functions for the 3x3 grayscale morphology block
// depends on nothing; used by the top level and every gm3 module but gm3_line_ram
package gm3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int OROW_W     = $clog2(MAX_HEIGHT);
  localparam int CMP_W      = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = FIFO_AW + 2;

  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT = HEIGHT_W'(480);

  localparam logic [PIX_W-1:0] PAD_ERODE  = '1;
  localparam logic [PIX_W-1:0] PAD_DILATE = '0;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  // result bookkeeping that travels with a tick
  typedef struct packed {
    logic res;
    logic top;
    logic bot;
    logic left;
    logic right;
    logic last;
  } flags_t;

  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] px;
    flags_t           flags;
  } tick_t;

  // one window column, top is two rows up
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] pix;
  } result_t;

  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] v);
    logic [WIDTH_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = WIDTH_W'(1);
    end else if (CMP_W'(v) > CMP_W'(MAX_WIDTH)) begin
      r = WIDTH_W'(MAX_WIDTH);
    end
    return r;
  endfunction

  function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] v);
    logic [HEIGHT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = HEIGHT_W'(1);
    end else if ((HEIGHT_W + 1)'(v) > (HEIGHT_W + 1)'(MAX_HEIGHT)) begin
      r = HEIGHT_W'(MAX_HEIGHT);
    end
    return r;
  endfunction

  // min for erosion, max for dilation
  function automatic logic [PIX_W-1:0] pick_px(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic dil);
    logic [PIX_W-1:0] r;
    if (dil) begin
      r = (a > b) ? a : b;
    end else begin
      r = (a < b) ? a : b;
    end
    return r;
  endfunction

endpackage

### design/grayscale_morphology_3x3.sv
// grayscale_morphology_3x3: streaming 3x3 grayscale erosion / dilation, top level
// depends on gm3_pkg, gm3_ctrl, gm3_line_ram, gm3_window, gm3_out_fifo and the defines header
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+------------------------------------------
//   s_      | in  | s_tvalid/s_tready | s_tdata = pixel_in, s_tuser = command
//   m_      | out | m_tvalid/m_tready | m_tdata = pixel_out, m_tlast = frame_last
//   cfg_    | in  | cfg_we            | cfg_index = register, cfg_data = value
//
// one request per clock while s_tready holds; each but a mid-frame drain ticks the line
// memory once (read, then write back); a result passes stage 1 and the window register,
// then is pushed into the queue, from which m_ can take it
// s_tready drops once queued plus in-flight results reach the 4-entry queue depth
// synchronous active-high reset; no clearing pass, unwritten line memory rows are padded
`include "grayscale_morphology_3x3_defines.svh"

module grayscale_morphology_3x3 (
  input  logic                              clk,
  input  logic                              rst,
  // slave side
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [gm3_pkg::PIX_W-1:0]         s_tdata,   // [7:0] pixel_in
  input  logic                              s_tuser,   // [0] command
  // master side
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gm3_pkg::PIX_W-1:0]         m_tdata,   // [7:0] pixel_out
  output logic                              m_tlast,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [gm3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gm3_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gm3_pkg::*;

  tick_t             tick;      // request as decoded against the raster position
  tick_t             s1;        // stage waiting for the line memory read data
  logic              mode;
  logic [2*PIX_W-1:0] rd_data;  // [7:0] two rows up, [15:8] one row up
  logic [2*PIX_W-1:0] wr_data;
  col_t              new_col;
  logic              res_valid;
  result_t           res;
  result_t           out_data;
  logic [FIFO_AW:0]  fifo_count;
  logic [OCC_W-1:0]  occ;
  logic              s_accept;
  logic              m_accept;

  assign s_accept = s_tvalid && s_tready;
  assign m_accept = m_tvalid && m_tready;

  // position counters and registers; a drain during a frame gives no tick
  gm3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (s_accept),
    .command   (s_tuser),
    .pixel_in  (s_tdata),
    .tick      (tick),
    .mode      (mode)
  );

  // stage 1 holds the tick while its column comes out of the line memory
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= tick;
    end
  end

  // the older row moves down, the new pixel becomes the row above
  assign wr_data = {s1.px, rd_data[2*PIX_W-1:PIX_W]};

  // with a one-pixel row the next read hits the entry being written, the ram bypasses it
  gm3_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * PIX_W)
  ) u_line_ram (
    .clk     (clk),
    .rd_en   (tick.valid),
    .rd_addr (tick.addr),
    .rd_data (rd_data),
    .wr_en   (s1.valid),
    .wr_addr (s1.addr),
    .wr_data (wr_data)
  );

  assign new_col.top = rd_data[PIX_W-1:0];
  assign new_col.mid = rd_data[2*PIX_W-1:PIX_W];
  assign new_col.bot = s1.px;

  gm3_window u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1.valid),
    .in_col    (new_col),
    .in_flags  (s1.flags),
    .mode      (mode),
    .res_valid (res_valid),
    .res       (res)
  );

  gm3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (m_accept),
    .out_valid (m_tvalid),
    .out_data  (out_data),
    .count     (fifo_count)
  );

  // results queued plus results still in flight must fit the queue
  assign occ = OCC_W'(fifo_count) + OCC_W'(s1.flags.res) + OCC_W'(res_valid);
  assign s_tready = occ < OCC_W'(FIFO_DEPTH);

  assign m_tdata = out_data.pix;
  assign m_tlast = out_data.last;

  `GM3_ASSERT_IMPL(a_occ_bound, 1'b1, occ <= OCC_W'(FIFO_DEPTH))
  `GM3_ASSERT_NEXT(a_last_reaches_window, s1.valid && s1.flags.res && s1.flags.last, res_valid && res.last)
  `GM3_ASSERT_IMPL(a_res_needs_tick, s1.flags.res, s1.valid)

endmodule

### design/gm3_line_ram.sv
// gm3_line_ram: one-port-write, one-port-read synchronous memory with write-first bypass
// generic, no package dependency; holds the two buffered rows of the gm3 block
module gm3_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // same-address write in the same cycle wins over the stored word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

### design/gm3_ctrl.sv
// gm3_ctrl: configuration registers and raster position counters of the gm3 block
// depends on gm3_pkg and grayscale_morphology_3x3_defines.svh
`include "grayscale_morphology_3x3_defines.svh"

module gm3_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gm3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gm3_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             accept,
  input  logic                             command,
  input  logic [gm3_pkg::PIX_W-1:0]        pixel_in,
  output gm3_pkg::tick_t                   tick,
  output logic                             mode
);
  import gm3_pkg::*;

  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic [COL_W-1:0]    col;
  logic [HEIGHT_W-1:0] row;
  logic [COL_W-1:0]    ocol;
  logic [OROW_W-1:0]   orow;

  logic             receiving;
  logic             cfg_hit;
  logic             col_wrap;
  logic             ocol_wrap;
  logic             orow_last;
  logic             res_ok;
  logic [PIX_W-1:0] pad;

  always_comb begin
    receiving = row < height_eff;
    pad       = (mode == MODE_DILATE) ? PAD_DILATE : PAD_ERODE;
    cfg_hit   = cfg_we && ((cfg_index == REG_MODE) || (cfg_index == REG_WIDTH) ||
                           (cfg_index == REG_HEIGHT));
    col_wrap  = (CMP_W'(col) + CMP_W'(1)) == CMP_W'(width_eff);
    ocol_wrap = (CMP_W'(ocol) + CMP_W'(1)) == CMP_W'(width_eff);
    orow_last = (HEIGHT_W'(orow) + HEIGHT_W'(1)) == height_eff;
    // first result once a row and one pixel have gone by
    res_ok    = (row >= HEIGHT_W'(2)) || ((row == HEIGHT_W'(1)) && (col != '0));

    tick.valid       = accept && !((command == CMD_DRAIN) && receiving);
    tick.addr        = col;
    tick.px          = ((command == CMD_PIXEL) && receiving) ? pixel_in : pad;
    tick.flags.res   = tick.valid && res_ok;
    tick.flags.top   = orow == '0;
    tick.flags.bot   = orow_last;
    tick.flags.left  = ocol == '0;
    tick.flags.right = ocol_wrap;
    tick.flags.last  = tick.flags.res && ocol_wrap && orow_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_ERODE;
      width_eff  <= RST_WIDTH;
      height_eff <= RST_HEIGHT;
      col        <= '0;
      row        <= '0;
      ocol       <= '0;
      orow       <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        REG_MODE:   mode <= cfg_data[0];
        REG_WIDTH:  width_eff <= eff_width(cfg_data[WIDTH_W-1:0]);
        REG_HEIGHT: height_eff <= eff_height(cfg_data[HEIGHT_W-1:0]);
        default:    mode <= mode;
      endcase
      col  <= '0;
      row  <= '0;
      ocol <= '0;
      orow <= '0;
    end else if (tick.valid) begin
      if (tick.flags.last) begin
        col  <= '0;
        row  <= '0;
        ocol <= '0;
        orow <= '0;
      end else begin
        if (col_wrap) begin
          col <= '0;
          row <= row + HEIGHT_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
        if (tick.flags.res) begin
          if (ocol_wrap) begin
            ocol <= '0;
            orow <= orow + OROW_W'(1);
          end else begin
            ocol <= ocol + COL_W'(1);
          end
        end
      end
    end
  end

  `GM3_ASSERT_IMPL(a_col_in_row, 1'b1, CMP_W'(col) < CMP_W'(width_eff))
  `GM3_ASSERT_IMPL(a_row_bound, 1'b1, (HEIGHT_W + 1)'(row) <= ((HEIGHT_W + 1)'(height_eff) + (HEIGHT_W + 1)'(1)))
  `GM3_ASSERT_IMPL(a_orow_in_frame, 1'b1, HEIGHT_W'(orow) < height_eff)

endmodule

### design/gm3_window.sv
// gm3_window: 3x3 pixel window, border padding and the min/max reduction
// depends on gm3_pkg
module gm3_window (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  gm3_pkg::col_t    in_col,
  input  gm3_pkg::flags_t  in_flags,
  input  logic             mode,
  output logic             res_valid,
  output gm3_pkg::result_t res
);
  import gm3_pkg::*;

  col_t   win [3];
  flags_t flags2;

  logic [PIX_W-1:0] pad;
  logic [PIX_W-1:0] colv [3];
  logic [PIX_W-1:0] c_left;
  logic [PIX_W-1:0] c_right;
  logic             dil;

  // only the result strobe needs a reset, the window contents are padded until valid
  always_ff @(posedge clk) begin
    if (rst) begin
      flags2.res <= 1'b0;
    end else begin
      flags2.res <= in_valid && in_flags.res;
      if (in_valid) begin
        win[0]       <= win[1];
        win[1]       <= win[2];
        win[2]       <= in_col;
        flags2.top   <= in_flags.top;
        flags2.bot   <= in_flags.bot;
        flags2.left  <= in_flags.left;
        flags2.right <= in_flags.right;
        flags2.last  <= in_flags.last;
      end
    end
  end

  always_comb begin
    dil = mode == MODE_DILATE;
    pad = dil ? PAD_DILATE : PAD_ERODE;
    for (int k = 0; k < 3; k++) begin
      colv[k] = pick_px(pick_px(flags2.top ? pad : win[k].top, win[k].mid, dil),
                        flags2.bot ? pad : win[k].bot, dil);
    end
    c_left    = flags2.left ? pad : colv[0];
    c_right   = flags2.right ? pad : colv[2];
    res.pix   = pick_px(pick_px(c_left, colv[1], dil), c_right, dil);
    res.last  = flags2.last;
    res_valid = flags2.res;
  end

endmodule

### design/gm3_out_fifo.sv
// gm3_out_fifo: small result queue between the window and the output channel
// depends on gm3_pkg
module gm3_out_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  gm3_pkg::result_t           push_data,
  input  logic                       pop,
  output logic                       out_valid,
  output gm3_pkg::result_t           out_data,
  output logic [gm3_pkg::FIFO_AW:0]  count
);
  import gm3_pkg::*;

  result_t            slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + FIFO_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + FIFO_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (FIFO_AW + 1)'(1);
        2'b01:   count <= count - (FIFO_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  assign out_valid = count != '0;
  assign out_data  = slots[rptr];

endmodule

### sim/grayscale_morphology_3x3_tb.sv
`timescale 1ns / 1ps
// grayscale_morphology_3x3_tb: self-checking bench for the streaming 3x3 erosion / dilation
// block; predicts every output pixel from its own line memory and window copy
// depends on gm3_pkg and the grayscale_morphology_3x3 design files
module grayscale_morphology_3x3_tb;
  import gm3_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 16;     // pipeline plus result queue, with margin
  localparam int unsigned RANDOM_ITEMS  = 550;
  localparam int unsigned MAX_REPORTS   = 200;

  // register index that maps to no register; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             last;
  } out_pixel_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata;   // [7:0] pixel_in
  logic                  s_tuser;   // [0] command
  logic                  m_tvalid;
  logic                  m_tready;
  logic [PIX_W-1:0]      m_tdata;   // [7:0] pixel_out
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // idling knobs, percent of cycles
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  int unsigned errors;
  int unsigned cycle_count;
  int unsigned counted_items;   // pixels and flush requests, mid-frame drains left out

  // mirror of the block: registers, line memory, window and raster position
  logic                mode_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [PIX_W-1:0]    line_mem [0:2*MAX_WIDTH-1];
  logic [PIX_W-1:0]    win [0:8];
  int unsigned         col_pos;
  int unsigned         row_pos;

  // output pixels predicted but not yet seen, oldest first
  out_pixel_t awaited[$];

  grayscale_morphology_3x3 uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // register value 0 acts as 1, anything above the top acts as the top
  function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned top);
    int unsigned v;
    v = raw;
    if (v == 0) v = 1;
    if (v > top) v = top;
    return v;
  endfunction

  // one accepted request through the line memory and window; queues the output pixel
  // if this request completes a neighborhood
  task automatic apply_window(input logic cmd, input logic [PIX_W-1:0] px_in);
    int unsigned w, h, c, r, rc, cc, pos, q, total;
    logic dil, receiving, take;
    logic [PIX_W-1:0] pad, px, acc, v;
    out_pixel_t res;
    w = clamp_dim(width_q, MAX_WIDTH);
    h = clamp_dim(height_q, MAX_HEIGHT);
    dil = (mode_q == MODE_DILATE);
    pad = dil ? PAD_DILATE : PAD_ERODE;
    receiving = (row_pos < h);
    take = (cmd == CMD_PIXEL) && receiving;
    // drain while the frame is still arriving: ignored
    if (!take && receiving) return;
    // past the last pixel every request is a drain, its value dropped
    px = take ? px_in : pad;
    c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    r = row_pos;

    // shift the window left, new column from the two stored rows and the new pixel
    for (int k = 0; k < 3; k++) begin
      win[k*3]     = win[k*3 + 1];
      win[k*3 + 1] = win[k*3 + 2];
    end
    win[2] = line_mem[c];
    win[5] = line_mem[MAX_WIDTH + c];
    win[8] = px;
    line_mem[c] = line_mem[MAX_WIDTH + c];
    line_mem[MAX_WIDTH + c] = px;

    pos = r * w + c;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end

    // output lags one row plus one pixel; early drains of one-row frames give nothing
    if (pos < w + 1) return;
    q = pos - w - 1;
    total = w * h;
    if (q >= total) begin
      col_pos = 0;
      row_pos = 0;
      return;
    end
    rc = q / w;
    cc = q % w;

    // neighbors outside the frame read the pad, which never wins
    acc = pad;
    for (int k = 0; k < 9; k++) begin
      v = win[k];
      if ((k / 3 == 0 && rc == 0) || (k / 3 == 2 && rc + 1 >= h) ||
          (k % 3 == 0 && cc == 0) || (k % 3 == 2 && cc + 1 >= w)) begin
        v = pad;
      end
      if (dil ? (v > acc) : (v < acc)) acc = v;
    end
    res.pix  = acc;
    res.last = (q + 1 == total);
    awaited.push_back(res);
    if (res.last) begin
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  // one request on the slave side, with random idle cycles in front of it
  task automatic send_request(input logic cmd, input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_window(cmd, px);
  endtask

  // sender holds off until every predicted pixel has left the block
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited.size() != 0);
  endtask

  // idle block: nothing awaited and the pipeline empty, safe for register writes
  task automatic quiesce();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_we stays high here; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    logic restart;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    restart = 1'b1;
    case (idx)
      REG_MODE:   mode_q   = value[0];
      REG_WIDTH:  width_q  = value[WIDTH_W-1:0];
      REG_HEIGHT: height_q = value[HEIGHT_W-1:0];
      default:    restart  = 1'b0;
    endcase
    // any real register write drops the frame in progress
    if (restart) begin
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  // mode write carries random junk above bit 0 to exercise the masking
  task automatic set_format(input logic m, input logic [CFG_DATA_W-1:0] width_raw,
                            input logic [CFG_DATA_W-1:0] height_raw);
    quiesce();
    write_reg(REG_MODE, {12'($urandom), m});
    write_reg(REG_WIDTH, width_raw);
    write_reg(REG_HEIGHT, height_raw);
    cfg_we <= 1'b0;
  endtask

  // one frame at the programmed size, then width+1 flush requests of mixed command;
  // noise adds ignored mid-frame drains, pause_at holds off until all output is out,
  // stop_after abandons the frame early with no flush
  task automatic send_frame(input int unsigned noise_pct, input int unsigned pause_at,
                            input int unsigned stop_after);
    int unsigned cols, n, full;
    cols = clamp_dim(width_q, MAX_WIDTH);
    full = cols * clamp_dim(height_q, MAX_HEIGHT);
    n = (stop_after != 0 && stop_after < full) ? stop_after : full;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) send_request(CMD_DRAIN, PIX_W'($urandom));
      if (pause_at != 0 && i == pause_at) wait_for_results();
      send_request(CMD_PIXEL, PIX_W'($urandom));
      counted_items++;
    end
    if (n == full) begin
      for (int unsigned i = 0; i <= cols; i++) begin
        send_request($urandom_range(1) ? CMD_DRAIN : CMD_PIXEL, PIX_W'($urandom));
        counted_items++;
      end
    end
  endtask

  // oversize width clamps to the widest row; one full row plus a few pixels writes
  // every line memory entry and checks the first results of the frame
  task automatic test_line_memory_fill();
    send_idle_pct = 0;
    stall_pct = 0;
    set_format(MODE_ERODE, 13'h07FF, 13'd2);
    send_frame(0, 0, 1030);
  endtask

  // 3x3 frame of extreme pixels in both modes, an ignored drain in the middle,
  // flush mixes drains with pixels that arrive after the frame
  task automatic test_corner_pixels();
    logic [PIX_W-1:0] corner [9];
    corner = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h00};
    for (int m = 0; m < 2; m++) begin
      set_format(m ? MODE_DILATE : MODE_ERODE, 13'd3, 13'd3);
      for (int i = 0; i < 9; i++) begin
        if (i == 4) send_request(CMD_DRAIN, 8'hFF);
        send_request(CMD_PIXEL, corner[i]);
      end
      for (int i = 0; i < 4; i++) begin
        send_request((i % 2) ? CMD_PIXEL : CMD_DRAIN, 8'h00);
      end
    end
  endtask

  // zero registers, bits above the register width, one-row frames
  task automatic test_size_clamping();
    send_idle_pct = 63;
    stall_pct = 0;
    set_format(MODE_DILATE, 13'd0, 13'd0);         // acts as 1x1
    send_frame(0, 0, 0);
    set_format(MODE_DILATE, 13'h1803, 13'd2);      // high bits dropped, width 3
    send_frame(0, 0, 0);
    set_format(MODE_ERODE, 13'd2, 13'd1);          // first drain lands before frame start
    send_frame(0, 0, 0);
  endtask

  // one-pixel-wide frames of the greatest height, exact and clamped, abandoned
  // after a few rows
  task automatic test_tall_frames();
    send_idle_pct = 36;
    stall_pct = 36;
    set_format(MODE_DILATE, 13'd1, 13'h1000);
    send_frame(0, 0, 24);
    set_format(MODE_ERODE, 13'h0801, 13'h1FFF);
    send_frame(0, 0, 24);
  endtask

  // a write mid-frame drops the frame; a write to the spare index leaves it running
  task automatic test_frame_restart();
    send_idle_pct = 0;
    stall_pct = 63;
    set_format(MODE_ERODE, 13'd4, 13'd4);
    send_frame(0, 0, 7);
    set_format(MODE_DILATE, 13'd4, 13'd4);
    send_frame(0, 0, 0);

    set_format(MODE_ERODE, 13'd5, 13'd3);
    send_frame(0, 0, 6);
    quiesce();
    write_reg(REG_SPARE, 13'h1FFF);
    cfg_we <= 1'b0;
    repeat (9) send_request(CMD_PIXEL, PIX_W'($urandom));
    repeat (6) send_request(CMD_DRAIN, PIX_W'($urandom));
  endtask

  // sender stops mid-frame until every predicted pixel is out, then carries on
  task automatic test_drained_pause();
    send_idle_pct = 36;
    stall_pct = 36;
    set_format(MODE_DILATE, 13'd6, 13'd5);
    send_frame(10, 13, 0);
  endtask

  // mostly small well-formed frames with random content, some wider ones,
  // noise drains, pauses and abandoned frames; idling changes every quarter
  task automatic test_random_frames();
    int unsigned start, cols, rows, sel, pause_at, stop_after;
    logic [CFG_DATA_W-1:0] width_raw, height_raw;
    start = counted_items;
    while (counted_items - start < RANDOM_ITEMS) begin
      case ((counted_items - start) * 4 / RANDOM_ITEMS)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 63; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      sel = $urandom_range(99);
      if (sel < 70) cols = $urandom_range(8, 1);
      else if (sel < 96) cols = $urandom_range(64, 9);
      else cols = $urandom_range(128, 65);
      rows = (cols > 64) ? $urandom_range(2, 1) : $urandom_range(8, 1);
      // bits above the register width are dropped; a width or height of 1 may go in as 0
      width_raw  = {2'($urandom), 11'(cols)};
      height_raw = 13'(rows);
      if (cols == 1 && $urandom_range(1)) width_raw = '0;
      if (rows == 1 && $urandom_range(1)) height_raw = '0;
      set_format(1'($urandom), width_raw, height_raw);
      pause_at   = ($urandom_range(9) == 0) ? $urandom_range(cols * rows) : 0;
      stop_after = ($urandom_range(9) == 0) ? $urandom_range(cols * rows) : 0;
      send_frame($urandom_range(1) ? 10 : 0, pause_at, stop_after);
    end
  endtask

  // compare each output pixel with the oldest prediction
  always @(posedge clk) begin
    out_pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited.size() == 0) begin
        if (errors < MAX_REPORTS) begin
          $display("%0t: unexpected output, expected none, actual pixel %0d last %0b",
                   $time, m_tdata, m_tlast);
        end
        errors++;
      end else begin
        want = awaited.pop_front();
        if (m_tdata !== want.pix || m_tlast !== want.last) begin
          if (errors < MAX_REPORTS) begin
            $display("%0t: mismatch, expected pixel %0d last %0b, actual pixel %0d last %0b",
                     $time, want.pix, want.last, m_tdata, m_tlast);
          end
          errors++;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // run limit
  initial begin
    cycle_count = 0;
    do begin
      @(posedge clk);
      cycle_count++;
    end while (cycle_count < CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_PIXEL;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_MODE;
    cfg_data  = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    errors        = 0;
    counted_items = 0;
    // mirror starts from the reset state of the block
    mode_q   = MODE_ERODE;
    width_q  = RST_WIDTH;
    height_q = RST_HEIGHT;
    col_pos  = 0;
    row_pos  = 0;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i]) win[i] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_line_memory_fill();
    test_corner_pixels();
    test_size_clamping();
    test_tall_frames();
    test_frame_restart();
    test_drained_pause();
    test_random_frames();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
